@@ hw/rtl/srhe_pkg.sv @@
// Package for the spinning rotor heading estimator.
// Holds item and result types, mode and register codes, CORDIC constants and rounding helpers.
// No dependencies.
`timescale 1ns / 1ps
package srhe_pkg;

  localparam int MaxBlades = 4;
  localparam int CW        = 37;  // CORDIC x/y width
  localparam int ZW        = 24;  // CORDIC angle width, 2^-20 rad

  localparam logic [1:0] MODE_WAIT    = 2'd0;
  localparam logic [1:0] MODE_CAPTURE = 2'd1;
  localparam logic [1:0] MODE_RUN     = 2'd2;
  localparam logic [1:0] MODE_FAULT   = 2'd3;

  localparam logic [2:0] REG_CAPTURE = 3'd0;
  localparam logic [2:0] REG_BLADES  = 3'd1;
  localparam logic [2:0] REG_OFF0    = 3'd2;
  localparam logic [2:0] REG_OFF1    = 3'd3;
  localparam logic [2:0] REG_OFF2    = 3'd4;
  localparam logic [2:0] REG_OFF3    = 3'd5;

  localparam logic signed [ZW-1:0] PI_A      = 24'sd3294199;
  localparam logic signed [ZW-1:0] HALF_PI_A = 24'sd1647099;
  localparam logic signed [CW-1:0] K30       = 37'sd652032875;
  localparam logic signed [24:0]   RPM_MUL   = 25'sd10013163;

  typedef struct packed {
    logic               attitude_valid;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [23:0] rate_roll;
    logic signed [23:0] rate_pitch;
    logic signed [23:0] rate_yaw;
  } item_t;

  typedef struct packed {
    logic [1:0]         mode_now;
    logic               outputs_valid;
    logic signed [15:0] heading_quat_w;
    logic signed [15:0] heading_quat_z;
    logic signed [23:0] despun_roll;
    logic signed [23:0] despun_pitch;
    logic signed [15:0] spin_rpm;
    logic [1:0]         blade_number;
    logic signed [15:0] blade_azimuth;
    logic               last_of_tick;
  } res_t;

  typedef struct packed {
    logic                 start;
    logic                 vectoring;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [ZW-1:0] z;
    logic signed [15:0]   cos;
    logic signed [15:0]   sin;
  } cordic_rsp_t;

  function automatic logic signed [ZW-1:0] atan_tab(input logic [3:0] i);
    logic signed [ZW-1:0] t;
    unique case (i)
      4'd0:    t = 24'sd823550;
      4'd1:    t = 24'sd486170;
      4'd2:    t = 24'sd256879;
      4'd3:    t = 24'sd130396;
      4'd4:    t = 24'sd65451;
      4'd5:    t = 24'sd32757;
      4'd6:    t = 24'sd16383;
      4'd7:    t = 24'sd8192;
      4'd8:    t = 24'sd4096;
      4'd9:    t = 24'sd2048;
      4'd10:   t = 24'sd1024;
      4'd11:   t = 24'sd512;
      4'd12:   t = 24'sd256;
      4'd13:   t = 24'sd128;
      4'd14:   t = 24'sd64;
      default: t = 24'sd32;
    endcase
    return t;
  endfunction

  function automatic logic signed [15:0] ang_q13(input logic signed [ZW-1:0] a);
    logic signed [24:0] t;
    t = (25'(a) + 25'sd64) >>> 7;
    if (t > 25'sd25736) t = 25'sd25736;
    else if (t < -25'sd25736) t = -25'sd25736;
    return 16'(t);
  endfunction

  function automatic logic signed [15:0] rnd_sc(input logic signed [CW-1:0] v);
    logic signed [CW:0] t;
    t = (38'(v) + 38'sd32768) >>> 16;
    if (t > 38'sd16384) t = 38'sd16384;
    else if (t < -38'sd16384) t = -38'sd16384;
    return 16'(t);
  endfunction

  function automatic logic signed [23:0] sat_rate(input logic signed [39:0] acc);
    logic signed [40:0] t;
    t = (41'(acc) + 41'sd8192) >>> 14;
    if (t > 41'sd8388607) t = 41'sd8388607;
    else if (t < -41'sd8388608) t = -41'sd8388608;
    return 24'(t);
  endfunction

endpackage

@@ hw/rtl/srhe_front.sv @@
// Front end: two-entry input queue that accepts tick items.
// Depends on srhe_pkg.
`timescale 1ns / 1ps
module srhe_front import srhe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  avail_o,
  output item_t head_o
);

  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rp_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & avail_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= item_i;
  end

endmodule

@@ hw/rtl/srhe_cordic.sv @@
// Iterative CORDIC, 16 iterations, vectoring (atan2) or rotation (sin/cos).
// Depends on srhe_pkg.
`timescale 1ns / 1ps
module srhe_cordic import srhe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cordic_req_t req_i,
  output cordic_rsp_t rsp_o
);

  logic signed [CW-1:0] x_q, y_q, dx, dy;
  logic signed [ZW-1:0] z_q, tab;
  logic [3:0]           cnt_q;
  logic                 busy_q, done_q, vec_q, neg_q, zero_q, up;
  logic signed [15:0]   c_r, s_r;

  assign dx  = y_q >>> cnt_q;
  assign dy  = x_q >>> cnt_q;
  assign tab = atan_tab(cnt_q);
  assign up  = vec_q ? (y_q > 0) : (z_q < 0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      vec_q <= req_i.vectoring;
      if (req_i.vectoring) begin
        neg_q  <= 1'b0;
        zero_q <= (req_i.x == 0) && (req_i.y == 0);
        if (req_i.x < 0 && req_i.y >= 0) begin
          x_q <= req_i.y;
          y_q <= -req_i.x;
          z_q <= HALF_PI_A;
        end else if (req_i.x < 0) begin
          x_q <= -req_i.y;
          y_q <= req_i.x;
          z_q <= -HALF_PI_A;
        end else begin
          x_q <= req_i.x;
          y_q <= req_i.y;
          z_q <= '0;
        end
      end else begin
        zero_q <= 1'b0;
        x_q    <= K30;
        y_q    <= '0;
        if (req_i.z > HALF_PI_A) begin
          z_q   <= req_i.z - PI_A;
          neg_q <= 1'b1;
        end else if (req_i.z < -HALF_PI_A) begin
          z_q   <= req_i.z + PI_A;
          neg_q <= 1'b1;
        end else begin
          z_q   <= req_i.z;
          neg_q <= 1'b0;
        end
      end
    end else if (busy_q) begin
      if (up) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + tab;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - tab;
      end
    end
  end

  assign c_r = rnd_sc(x_q);
  assign s_r = rnd_sc(y_q);

  always_comb begin
    rsp_o.done = done_q;
    rsp_o.z    = zero_q ? '0 : z_q;
    rsp_o.cos  = neg_q ? -c_r : c_r;
    rsp_o.sin  = neg_q ? -s_r : s_r;
  end

endmodule

@@ hw/rtl/srhe_back.sv @@
// Back end: mode sequencer with shared multiplier and CORDIC, emits results.
// Depends on srhe_pkg; drives srhe_cordic through cordic_req_t.
`timescale 1ns / 1ps
module srhe_back import srhe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               avail_i,
  input  item_t              head_i,
  output logic               pop_o,
  output cordic_req_t        creq_o,
  input  cordic_rsp_t        crsp_i,
  output logic               push_o,
  output res_t               res_o,
  input  logic               full_i,
  input  logic [12:0]        cap_i,
  input  logic [2:0]         blades_i,
  input  logic signed [15:0] off_i [MaxBlades]
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_M0   = 5'd1;
  localparam logic [4:0] S_M1   = 5'd2;
  localparam logic [4:0] S_M2   = 5'd3;
  localparam logic [4:0] S_M3   = 5'd4;
  localparam logic [4:0] S_YGO  = 5'd5;
  localparam logic [4:0] S_YWT  = 5'd6;
  localparam logic [4:0] S_HGO  = 5'd7;
  localparam logic [4:0] S_HWT  = 5'd8;
  localparam logic [4:0] S_SGO  = 5'd9;
  localparam logic [4:0] S_SWT  = 5'd10;
  localparam logic [4:0] S_VGO  = 5'd11;
  localparam logic [4:0] S_VWT  = 5'd12;
  localparam logic [4:0] S_D0   = 5'd13;
  localparam logic [4:0] S_D1   = 5'd14;
  localparam logic [4:0] S_D2   = 5'd15;
  localparam logic [4:0] S_D3   = 5'd16;
  localparam logic [4:0] S_D4   = 5'd17;
  localparam logic [4:0] S_EMIT = 5'd18;

  logic [4:0]         st_q;
  logic [1:0]         mode_q;
  logic [12:0]        cnt_q, cnt_nx;
  logic signed [27:0] ssum_q, csum_q, ssum_nx, csum_nx;
  logic signed [15:0] vh_q, yaw_q, hw_q, hz_q, s_q, c_q;
  item_t              it_q;
  logic signed [33:0] num_q, den_q;
  logic signed [39:0] dr_q, dp_q;
  logic signed [15:0] rpm_q;
  logic               prod_q;
  logic [2:0]         n_q, n_cfg;
  logic [1:0]         k_q;
  logic               last;

  logic signed [24:0] ma, mb, rabs;
  logic signed [49:0] prod;
  logic signed [16:0] rpm_m;
  logic signed [17:0] az;

  assign rabs = it_q.rate_yaw[23] ? -25'(it_q.rate_yaw) : 25'(it_q.rate_yaw);

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (st_q)
      S_M0: begin ma = 25'(it_q.quat_w); mb = 25'(it_q.quat_z); end
      S_M1: begin ma = 25'(it_q.quat_x); mb = 25'(it_q.quat_y); end
      S_M2: begin ma = 25'(it_q.quat_y); mb = 25'(it_q.quat_y); end
      S_M3: begin ma = 25'(it_q.quat_z); mb = 25'(it_q.quat_z); end
      S_D0: begin ma = 25'(it_q.rate_roll); mb = 25'(c_q); end
      S_D1: begin ma = 25'(it_q.rate_pitch); mb = 25'(s_q); end
      S_D2: begin ma = 25'(it_q.rate_pitch); mb = 25'(c_q); end
      S_D3: begin ma = 25'(it_q.rate_roll); mb = 25'(s_q); end
      S_D4: begin ma = rabs; mb = RPM_MUL; end
      default: ;
    endcase
  end

  assign prod  = ma * mb;
  assign rpm_m = it_q.rate_yaw[23] ? -17'(prod[47:32]) : 17'(prod[47:32]);

  always_comb begin
    creq_o.start     = (st_q == S_YGO) || (st_q == S_HGO) ||
                       (st_q == S_SGO) || (st_q == S_VGO);
    creq_o.vectoring = (st_q == S_YGO) || (st_q == S_VGO);
    creq_o.x         = '0;
    creq_o.y         = '0;
    creq_o.z         = '0;
    priority case (st_q)
      S_YGO: begin
        creq_o.y = 37'(num_q) <<< 1;
        creq_o.x = 37'sd268435456 - (37'(den_q) <<< 1);
      end
      S_VGO: begin
        creq_o.y = 37'(ssum_q);
        creq_o.x = 37'(csum_q);
      end
      S_HGO:   creq_o.z = 24'(vh_q) <<< 6;
      S_SGO:   creq_o.z = 24'(yaw_q) <<< 7;
      default: ;
    endcase
  end

  assign ssum_nx = ssum_q + 28'(crsp_i.sin);
  assign csum_nx = csum_q + 28'(crsp_i.cos);
  assign cnt_nx  = cnt_q + 13'd1;

  always_comb begin
    if (blades_i == 3'd0) n_cfg = 3'd1;
    else if (blades_i > 3'(MaxBlades)) n_cfg = 3'(MaxBlades);
    else n_cfg = blades_i;
  end

  assign last = ({1'b0, k_q} == (n_q - 3'd1));

  always_comb begin
    az = 18'(yaw_q) + 18'(off_i[k_q]);
    if (az >= 18'sd25736) az = az - 18'sd51472;
    else if (az < -18'sd25736) az = az + 18'sd51472;
  end

  always_comb begin
    res_o                = '0;
    res_o.mode_now       = mode_q;
    res_o.outputs_valid  = prod_q;
    res_o.last_of_tick   = last;
    if (prod_q) begin
      res_o.heading_quat_w = hw_q;
      res_o.heading_quat_z = hz_q;
      res_o.despun_roll    = sat_rate(dr_q);
      res_o.despun_pitch   = sat_rate(dp_q);
      res_o.spin_rpm       = rpm_q;
      res_o.blade_number   = k_q;
      res_o.blade_azimuth  = 16'(az);
    end
  end

  assign push_o = (st_q == S_EMIT) && !full_i;
  assign pop_o  = (st_q == S_IDLE) && avail_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      mode_q <= MODE_WAIT;
      cnt_q  <= '0;
      ssum_q <= '0;
      csum_q <= '0;
      vh_q   <= '0;
      prod_q <= 1'b0;
      n_q    <= 3'd1;
      k_q    <= '0;
    end else begin
      unique case (st_q)
        S_IDLE: begin
          if (avail_i) begin
            k_q    <= '0;
            n_q    <= 3'd1;
            prod_q <= 1'b0;
            st_q   <= S_EMIT;
            unique case (mode_q)
              MODE_WAIT: if (head_i.attitude_valid) mode_q <= MODE_CAPTURE;
              MODE_CAPTURE: st_q <= S_M0;
              MODE_RUN: begin
                if (!head_i.attitude_valid) begin
                  mode_q <= MODE_FAULT;
                end else begin
                  prod_q <= 1'b1;
                  n_q    <= n_cfg;
                  st_q   <= S_M0;
                end
              end
              default: begin
                if (head_i.attitude_valid) begin
                  cnt_q  <= '0;
                  ssum_q <= '0;
                  csum_q <= '0;
                  mode_q <= MODE_WAIT;
                end
              end
            endcase
          end
        end
        S_M0: st_q <= S_M1;
        S_M1: st_q <= S_M2;
        S_M2: st_q <= S_M3;
        S_M3: st_q <= S_YGO;
        S_YGO: st_q <= S_YWT;
        S_YWT: if (crsp_i.done) st_q <= (mode_q == MODE_CAPTURE) ? S_SGO : S_HGO;
        S_HGO: st_q <= S_HWT;
        S_HWT: if (crsp_i.done) st_q <= S_SGO;
        S_SGO: st_q <= S_SWT;
        S_SWT: begin
          if (crsp_i.done) begin
            if (mode_q == MODE_CAPTURE) begin
              ssum_q <= ssum_nx;
              csum_q <= csum_nx;
              cnt_q  <= cnt_nx;
              st_q   <= (cnt_nx >= cap_i) ? S_VGO : S_EMIT;
            end else begin
              st_q <= S_D0;
            end
          end
        end
        S_VGO: st_q <= S_VWT;
        S_VWT: begin
          if (crsp_i.done) begin
            vh_q   <= ang_q13(crsp_i.z);
            mode_q <= MODE_RUN;
            st_q   <= S_EMIT;
          end
        end
        S_D0: st_q <= S_D1;
        S_D1: st_q <= S_D2;
        S_D2: st_q <= S_D3;
        S_D3: st_q <= S_D4;
        S_D4: st_q <= S_EMIT;
        S_EMIT: begin
          if (!full_i) begin
            k_q <= k_q + 2'd1;
            if (last) st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) it_q <= head_i;
    unique case (st_q)
      S_M0: num_q <= 34'(prod);
      S_M1: num_q <= num_q + 34'(prod);
      S_M2: den_q <= 34'(prod);
      S_M3: den_q <= den_q + 34'(prod);
      S_D0: dr_q <= 40'(prod);
      S_D1: dr_q <= dr_q + 40'(prod);
      S_D2: dp_q <= 40'(prod);
      S_D3: dp_q <= dp_q - 40'(prod);
      S_D4: begin
        if (rpm_m > 17'sd32767) rpm_q <= 16'sh7fff;
        else if (rpm_m < -17'sd32768) rpm_q <= -16'sd32768;
        else rpm_q <= 16'(rpm_m);
      end
      S_YWT: if (crsp_i.done) yaw_q <= ang_q13(crsp_i.z);
      S_HWT: if (crsp_i.done) begin hw_q <= crsp_i.cos; hz_q <= crsp_i.sin; end
      S_SWT: if (crsp_i.done) begin c_q <= crsp_i.cos; s_q <= crsp_i.sin; end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/srhe_resq.sv @@
// Result queue: four entries between the sequencer and the output side.
// Depends on srhe_pkg.
`timescale 1ns / 1ps
module srhe_resq import srhe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t head_o
);

  res_t       mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);
  assign head_o  = mem_q[rp_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + 2'd1;
      if (do_pop) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'(do_push) - 3'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= res_i;
  end

endmodule

@@ hw/rtl/spinning_rotor_heading_estimator.sv @@
// Spinning rotor heading estimator, top level: APB registers, front queue,
// sequencer with shared CORDIC, result queue. Depends on srhe_pkg and submodules.
// The sequencer handles one tick at a time, taking the next from the front queue
// when idle; run ticks use three CORDIC passes, capture ticks two (three on the
// last sample). Reset: asynchronous, mode wait, registers at defaults.
`timescale 1ns / 1ps
module spinning_rotor_heading_estimator import srhe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               attitude_valid_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [23:0] rate_roll_i,
  input  logic signed [23:0] rate_pitch_i,
  input  logic signed [23:0] rate_yaw_i,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         mode_now_o,
  output logic               outputs_valid_o,
  output logic signed [15:0] heading_quat_w_o,
  output logic signed [15:0] heading_quat_z_o,
  output logic signed [23:0] despun_roll_o,
  output logic signed [23:0] despun_pitch_o,
  output logic signed [15:0] spin_rpm_o,
  output logic [1:0]         blade_number_o,
  output logic signed [15:0] blade_azimuth_o,
  output logic               last_of_tick_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [12:0]        cap_q;
  logic [2:0]         blades_q;
  logic signed [15:0] off_q [MaxBlades];
  logic               wr;
  logic [2:0]         idx;

  item_t       in_item, head;
  logic        avail, bpop, bpush, rfull;
  res_t        bres, rhead;
  cordic_req_t creq;
  cordic_rsp_t crsp;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= 13'd100;
      blades_q <= 3'd3;
      off_q[0] <= 16'sd0;
      off_q[1] <= 16'sd17157;
      off_q[2] <= -16'sd17157;
      off_q[3] <= 16'sd0;
    end else if (wr) begin
      unique case (idx)
        REG_CAPTURE: cap_q    <= pwdata[12:0];
        REG_BLADES:  blades_q <= pwdata[2:0];
        REG_OFF0:    off_q[0] <= pwdata[15:0];
        REG_OFF1:    off_q[1] <= pwdata[15:0];
        REG_OFF2:    off_q[2] <= pwdata[15:0];
        REG_OFF3:    off_q[3] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CAPTURE: prdata = 32'(cap_q);
      REG_BLADES:  prdata = 32'(blades_q);
      REG_OFF0:    prdata = 32'(off_q[0]);
      REG_OFF1:    prdata = 32'(off_q[1]);
      REG_OFF2:    prdata = 32'(off_q[2]);
      REG_OFF3:    prdata = 32'(off_q[3]);
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    in_item.attitude_valid = attitude_valid_i;
    in_item.quat_w         = quat_w_i;
    in_item.quat_x         = quat_x_i;
    in_item.quat_y         = quat_y_i;
    in_item.quat_z         = quat_z_i;
    in_item.rate_roll      = rate_roll_i;
    in_item.rate_pitch     = rate_pitch_i;
    in_item.rate_yaw       = rate_yaw_i;
  end

  srhe_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item),
    .full_o  (full),
    .pop_i   (bpop),
    .avail_o (avail),
    .head_o  (head)
  );

  srhe_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (creq),
    .rsp_o  (crsp)
  );

  srhe_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .avail_i  (avail),
    .head_i   (head),
    .pop_o    (bpop),
    .creq_o   (creq),
    .crsp_i   (crsp),
    .push_o   (bpush),
    .res_o    (bres),
    .full_i   (rfull),
    .cap_i    (cap_q),
    .blades_i (blades_q),
    .off_i    (off_q)
  );

  srhe_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bpush),
    .res_i   (bres),
    .full_o  (rfull),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (rhead)
  );

  assign mode_now_o       = rhead.mode_now;
  assign outputs_valid_o  = rhead.outputs_valid;
  assign heading_quat_w_o = rhead.heading_quat_w;
  assign heading_quat_z_o = rhead.heading_quat_z;
  assign despun_roll_o    = rhead.despun_roll;
  assign despun_pitch_o   = rhead.despun_pitch;
  assign spin_rpm_o       = rhead.spin_rpm;
  assign blade_number_o   = rhead.blade_number;
  assign blade_azimuth_o  = rhead.blade_azimuth;
  assign last_of_tick_o   = rhead.last_of_tick;

endmodule

@@ verif/srhe_checker.sv @@
// Checker for the spinning rotor heading estimator: watches the item, result
// and register channels, predicts every result and compares field by field.
// Depends on srhe_pkg.
`timescale 1ns / 1ps
module srhe_checker import srhe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  item_t              item_i,
  input  logic               pop_i,
  input  logic               empty_i,
  input  res_t               res_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [4:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam longint ArcTab [16] = '{823550, 486170, 256879, 130396, 65451, 32757,
                                     16383, 8192, 4096, 2048, 1024, 512, 256, 128,
                                     64, 32};

  // register copies
  logic [12:0]        capture_len;
  logic [2:0]         blades;
  logic signed [15:0] offsets [4];
  // estimator state
  logic [1:0]         mode_q;
  logic [12:0]        samples_q;
  int                 sin_acc, cos_acc;
  int                 heading_q;

  res_t expected_results [$];

  assign pending_o = expected_results.size();

  function automatic longint vector_angle(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI_A;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI_A;
      end
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ArcTab[i];
      end else begin
        x -= dx; y += dy; z -= ArcTab[i];
      end
    end
    return z;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint to_q13(longint a);
    return clip((a + 64) >>> 7, -25736, 25736);
  endfunction

  task automatic rotate(input longint a, output longint s, output longint c);
    longint x, y, dx, dy;
    bit flip;
    x = K30; y = 0; flip = 0;
    if (a > HALF_PI_A) begin
      a -= PI_A; flip = 1;
    end else if (a < -HALF_PI_A) begin
      a += PI_A; flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx; y += dy; a -= ArcTab[i];
      end else begin
        x += dx; y -= dy; a += ArcTab[i];
      end
    end
    x = clip((x + 32768) >>> 16, -16384, 16384);
    y = clip((y + 32768) >>> 16, -16384, 16384);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint yaw_of(item_t it);
    longint w, x, y, z;
    w = it.quat_w; x = it.quat_x; y = it.quat_y; z = it.quat_z;
    return to_q13(vector_angle(2 * (w * z + x * y), (64'sd1 <<< 28) - 2 * (y * y + z * z)));
  endfunction

  function automatic int wrap28(longint v);
    logic signed [27:0] t;
    t = v[27:0];
    return int'(t);
  endfunction

  task automatic predict_tick(item_t it);
    longint yaw, s, c, hs, hc, p, q, r, dr, dp, rpm, az, mag;
    int n;
    res_t e;
    bit produce;
    produce = 0;
    yaw = 0;
    p = it.rate_roll; q = it.rate_pitch; r = it.rate_yaw;
    case (mode_q)
      MODE_WAIT: if (it.attitude_valid) mode_q = MODE_CAPTURE;
      MODE_CAPTURE: begin
        yaw = yaw_of(it);
        rotate(yaw * 128, s, c);
        sin_acc = wrap28(longint'(sin_acc) + s);
        cos_acc = wrap28(longint'(cos_acc) + c);
        samples_q = samples_q + 13'd1;
        if (samples_q >= capture_len) begin
          heading_q = int'(to_q13(vector_angle(sin_acc, cos_acc)));
          mode_q = MODE_RUN;
        end
      end
      MODE_RUN: begin
        if (!it.attitude_valid) mode_q = MODE_FAULT;
        else produce = 1;
      end
      default: if (it.attitude_valid) begin
        samples_q = '0; sin_acc = 0; cos_acc = 0; mode_q = MODE_WAIT;
      end
    endcase
    if (!produce) begin
      e = '0;
      e.mode_now = mode_q;
      e.last_of_tick = 1'b1;
      expected_results.push_back(e);
      return;
    end
    yaw = yaw_of(it);
    rotate(longint'(heading_q) * 64, hs, hc);
    rotate(yaw * 128, s, c);
    dr = clip((p * c + q * s + 8192) >>> 14, -8388608, 8388607);
    dp = clip((q * c - p * s + 8192) >>> 14, -8388608, 8388607);
    mag = (r < 0 ? -r : r) * longint'(RPM_MUL);
    mag = mag >>> 32;
    rpm = clip(r < 0 ? -mag : mag, -32768, 32767);
    n = blades == 0 ? 1 : (blades > MaxBlades ? MaxBlades : int'(blades));
    for (int k = 0; k < n; k++) begin
      az = yaw + longint'(offsets[k]);
      while (az >= 25736) az -= 51472;
      while (az < -25736) az += 51472;
      e.mode_now       = mode_q;
      e.outputs_valid  = 1'b1;
      e.heading_quat_w = 16'(hc);
      e.heading_quat_z = 16'(hs);
      e.despun_roll    = 24'(dr);
      e.despun_pitch   = 24'(dp);
      e.spin_rpm       = 16'(rpm);
      e.blade_number   = 2'(k);
      e.blade_azimuth  = 16'(az);
      e.last_of_tick   = (k == n - 1);
      expected_results.push_back(e);
    end
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      fail_count_o = 0;
      capture_len  = 13'd100;
      blades       = 3'd3;
      offsets      = '{16'sd0, 16'sd17157, -16'sd17157, 16'sd0};
      mode_q       = MODE_WAIT;
      samples_q    = '0;
      sin_acc      = 0;
      cos_acc      = 0;
      heading_q    = 0;
      expected_results.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i) begin
        case (3'(paddr_i >> 2))
          REG_CAPTURE: capture_len = pwdata_i[12:0];
          REG_BLADES:  blades = pwdata_i[2:0];
          REG_OFF0:    offsets[0] = pwdata_i[15:0];
          REG_OFF1:    offsets[1] = pwdata_i[15:0];
          REG_OFF2:    offsets[2] = pwdata_i[15:0];
          REG_OFF3:    offsets[3] = pwdata_i[15:0];
          default: ;
        endcase
      end
      if (push_i && !full_i) predict_tick(item_i);
      if (pop_i && !empty_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no expectation waiting");
          fail_count_o++;
        end else begin
          e = expected_results.pop_front();
          check_field("mode_now", e.mode_now, res_i.mode_now);
          check_field("outputs_valid", e.outputs_valid, res_i.outputs_valid);
          check_field("heading_quat_w", e.heading_quat_w, res_i.heading_quat_w);
          check_field("heading_quat_z", e.heading_quat_z, res_i.heading_quat_z);
          check_field("despun_roll", e.despun_roll, res_i.despun_roll);
          check_field("despun_pitch", e.despun_pitch, res_i.despun_pitch);
          check_field("spin_rpm", e.spin_rpm, res_i.spin_rpm);
          check_field("blade_number", e.blade_number, res_i.blade_number);
          check_field("blade_azimuth", e.blade_azimuth, res_i.blade_azimuth);
          check_field("last_of_tick", e.last_of_tick, res_i.last_of_tick);
        end
      end
    end
  end

endmodule

@@ verif/spinning_rotor_heading_estimator_tb.sv @@
// Testbench top for the spinning rotor heading estimator: clock, reset, register
// phases, bursty item traffic and a stalling result reader; verdict from srhe_checker.
// Depends on srhe_pkg, srhe_checker and the estimator RTL.
`timescale 1ns / 1ps
module spinning_rotor_heading_estimator_tb;
  import srhe_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0, pop = 1'b0;
  logic        full, empty;
  item_t       item = '0;
  res_t        res;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic        pready;
  int          fail_count, pending;
  int          burst_left = 0;
  bit          start_hold = 0;

  always #2 clk_i = ~clk_i;

  spinning_rotor_heading_estimator u_dut (
    .clk_i, .rst_ni, .push, .full,
    .attitude_valid_i(item.attitude_valid),
    .quat_w_i(item.quat_w), .quat_x_i(item.quat_x),
    .quat_y_i(item.quat_y), .quat_z_i(item.quat_z),
    .rate_roll_i(item.rate_roll), .rate_pitch_i(item.rate_pitch),
    .rate_yaw_i(item.rate_yaw),
    .empty, .pop,
    .mode_now_o(res.mode_now), .outputs_valid_o(res.outputs_valid),
    .heading_quat_w_o(res.heading_quat_w), .heading_quat_z_o(res.heading_quat_z),
    .despun_roll_o(res.despun_roll), .despun_pitch_o(res.despun_pitch),
    .spin_rpm_o(res.spin_rpm), .blade_number_o(res.blade_number),
    .blade_azimuth_o(res.blade_azimuth), .last_of_tick_o(res.last_of_tick),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  srhe_checker u_checker (
    .clk_i, .rst_ni, .push_i(push), .full_i(full), .item_i(item),
    .pop_i(pop), .empty_i(empty), .res_i(res),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .fail_count_o(fail_count), .pending_o(pending)
  );

  task automatic reg_write(logic [2:0] idx, int value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 2; pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic configure(int cap, int nb, int o0, int o1, int o2, int o3);
    reg_write(REG_CAPTURE, cap);
    reg_write(REG_BLADES, nb);
    reg_write(REG_OFF0, o0);
    reg_write(REG_OFF1, o1);
    reg_write(REG_OFF2, o2);
    reg_write(REG_OFF3, o3);
  endtask

  task automatic send_tick(item_t it);
    push <= 1'b1;
    item <= it;
    do @(posedge clk_i); while (full);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(20)) @(posedge clk_i);
      burst_left = ($urandom_range(3) == 0) ? 40 : $urandom_range(1, 8);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic item_t tick(bit v, int w, int x, int y, int z, int p, int q, int r);
    item_t it;
    it.attitude_valid = v;
    it.quat_w = 16'(w); it.quat_x = 16'(x); it.quat_y = 16'(y); it.quat_z = 16'(z);
    it.rate_roll = 24'(p); it.rate_pitch = 24'(q); it.rate_yaw = 24'(r);
    return it;
  endfunction

  function automatic int rand_quat();
    case ($urandom_range(7))
      0: return 16384;
      1: return -16384;
      2: return 0;
      default: return int'($urandom_range(32768)) - 16384;
    endcase
  endfunction

  function automatic int rand_rate();
    case ($urandom_range(7))
      0: return 8388607;
      1: return -8388608;
      2: return int'($urandom_range(8000)) - 4000;
      default: return int'($signed(24'($urandom)));
    endcase
  endfunction

  function automatic int rand_offset();
    return int'($urandom_range(51472)) - 25736;
  endfunction

  // mostly valid attitude so capture completes and run is reached
  function automatic item_t rand_tick();
    return tick($urandom_range(15) != 0, rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                rand_rate(), rand_rate(), rand_rate());
  endfunction

  // result reader: stall level changes at random, one long hold-off
  initial begin
    int stall_pct;
    bit held;
    stall_pct = 0;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (start_hold && !held) begin
        held = 1;
        pop <= 1'b0;
        repeat (3000) @(posedge clk_i);
      end
      if ($urandom_range(63) == 0) stall_pct = $urandom_range(3) * 30;
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #2000000;
    $display("spinning_rotor_heading_estimator regression: fail");
    $finish;
  end

  initial begin
    int cap, nb, count;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    configure(1, 4, 25736, -25736, 0, 12345);
    send_tick(tick(0, 16384, 0, 0, 0, 0, 0, 0));
    send_tick(tick(1, 16384, 0, 0, 0, 0, 0, 0));
    send_tick(tick(0, 16384, 0, 0, 0, 0, 0, 0));
    send_tick(tick(1, 16384, -16384, 16384, -16384, 8388607, 8388607, 8388607));
    send_tick(tick(1, -16384, 16384, -16384, 16384, -8388608, -8388608, -8388608));
    send_tick(tick(1, 0, 0, 0, 16384, 4096, -4096, 1000));
    send_tick(tick(1, 0, 0, 0, 0, -1, 1, -1));
    send_tick(tick(1, 11585, 0, 0, -11585, 8388607, -8388608, 0));
    send_tick(tick(0, 0, 0, 0, 0, 0, 0, 0));
    send_tick(tick(0, 0, 0, 0, 0, 0, 0, 0));
    send_tick(tick(1, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // opposite samples cancel: zero sums
    configure(2, 0, -25736, 25736, 25735, -25735);
    send_tick(tick(1, 16384, 0, 0, 0, 0, 0, 0));
    send_tick(tick(1, 16384, 0, 0, 0, 0, 0, 0));
    send_tick(tick(1, 0, 0, 0, 16384, 0, 0, 0));
    send_tick(tick(1, 16384, 0, 0, 0, 100, 200, 300));
    send_tick(tick(0, 16384, 0, 0, 0, 0, 0, 0));
    send_tick(tick(1, 16384, 0, 0, 0, 0, 0, 0));
    drain();

    start_hold = 1;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin cap = 3;    nb = 3; end
        1: begin cap = 0;    nb = 1; end
        2: begin cap = 8;    nb = 7; end
        3: begin cap = 4096; nb = 2; end
        4: begin cap = 1;    nb = 5; end
        5: begin cap = 2;    nb = 4; end
        6: begin cap = 6;    nb = 0; end
        default: begin cap = $urandom_range(1, 5); nb = $urandom_range(1, 4); end
      endcase
      count = (cap == 4096) ? 30 : 70;
      configure(cap, nb, rand_offset(), rand_offset(), rand_offset(), rand_offset());
      for (int i = 0; i < count; i++) send_tick(rand_tick());
      drain();
    end

    if (fail_count == 0) $display("spinning_rotor_heading_estimator regression: pass");
    else $display("spinning_rotor_heading_estimator regression: fail");
    $finish;
  end

endmodule
